/* hdl/lcdfs_pkg.sv */
package lcdfs_pkg;

	// Function codes of a request
	localparam logic [1:0] FUNC_CMD   = 2'd0;
	localparam logic [1:0] FUNC_RAW   = 2'd1;
	localparam logic [1:0] FUNC_DIGIT = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	// Frame geometry: the first bit to leave sits at the top of the word
	localparam int unsigned FRAME_W = 17;
	localparam int unsigned LEN_W   = 5;
	localparam logic [LEN_W-1:0] LEN_CMD = 5'd12;
	localparam logic [LEN_W-1:0] LEN_SEG = 5'd17;

	// Leading flag bits of each frame kind
	localparam logic [3:0] CMD_FLAG = 4'b1000;
	localparam logic [2:0] SEG_FLAG = 3'b101;

	// Decimal point in the segment byte
	localparam logic [7:0] DOT_MASK = 8'h80;

	typedef struct packed {
		logic [FRAME_W-1:0] bits;
		logic [LEN_W-1:0]   len;
	} frame_t;

	// Seven-segment pattern of a digit; anything above nine is blank
	function automatic logic [7:0] digit_segs(input logic [7:0] digit);
		logic [7:0] segs;
		case (digit)
			8'd0: segs = 8'h7D;
			8'd1: segs = 8'h60;
			8'd2: segs = 8'h3E;
			8'd3: segs = 8'h7A;
			8'd4: segs = 8'h63;
			8'd5: segs = 8'h5B;
			8'd6: segs = 8'h5F;
			8'd7: segs = 8'h70;
			8'd8: segs = 8'h7F;
			8'd9: segs = 8'h7B;
			default: segs = 8'h00;
		endcase
		return segs;
	endfunction

	// Bit reversal of a byte, so that it leaves LSB first from an MSB-first shifter
	function automatic logic [7:0] reverse_byte(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

endpackage

/* hdl/lcdfs_shifter.sv */
module lcdfs_shifter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  lcdfs_pkg::frame_t   frame,
	input  logic                advance,
	output logic                busy,
	output logic                bit_out,
	output logic                last_out
);

	logic [lcdfs_pkg::FRAME_W-1:0] shift_q;
	logic [lcdfs_pkg::LEN_W-1:0]   count_q;

	// Load a new frame, or advance one bit per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= frame.len;
		end else if (advance) begin
			count_q <= count_q - lcdfs_pkg::LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= frame.bits;
		end else if (advance) begin
			shift_q <= {shift_q[lcdfs_pkg::FRAME_W-2:0], 1'b0};
		end
	end

	assign busy     = (count_q != '0);
	assign bit_out  = shift_q[lcdfs_pkg::FRAME_W-1];
	assign last_out = (count_q == lcdfs_pkg::LEN_W'(1));

endmodule

/* hdl/lcd_controller_serial_frame_sender.sv */
// The first bit of a frame is offered in the cycle after the request transfer.
// One bit per cycle while out_stall is low, from a single shift register and bit counter;
// a command frame has 12 bits, a segment or digit write 17 bits.
// A new request is taken in the cycle the last bit of the previous frame transfers.
// Function code three is taken and dropped with no output.
// Reset (arst_n low) clears the bit counter; the block comes up idle.
module lcd_controller_serial_frame_sender (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [4:0] address,
	input  logic [7:0] value,
	input  logic       dot,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       serial_bit,
	output logic       last
);

	logic              busy;
	logic              out_take;
	logic              in_take;
	logic              load;
	logic [5:0]        sent_addr;
	logic [7:0]        segs;
	lcdfs_pkg::frame_t frame;

	assign out_take = out_valid && !out_stall;
	// Hold requests while a frame is in flight, except on its final transfer
	assign in_stall = busy && !(out_take && last);
	assign in_take  = in_valid && !in_stall;
	assign load     = in_take && (func != lcdfs_pkg::FUNC_NONE);

	// Build the frame word: address is (2*address-1) mod 64
	assign sent_addr = {address, 1'b0} + 6'd63;

	always_comb begin
		segs = value;
		if (func == lcdfs_pkg::FUNC_DIGIT) begin
			segs = lcdfs_pkg::digit_segs(value);
			if (dot) begin
				segs = segs | lcdfs_pkg::DOT_MASK;
			end
		end
	end

	always_comb begin
		case (func)
			lcdfs_pkg::FUNC_CMD: begin
				frame.bits = {lcdfs_pkg::CMD_FLAG, value, 5'b0};
				frame.len  = lcdfs_pkg::LEN_CMD;
			end
			lcdfs_pkg::FUNC_RAW, lcdfs_pkg::FUNC_DIGIT: begin
				frame.bits = {lcdfs_pkg::SEG_FLAG, sent_addr, lcdfs_pkg::reverse_byte(segs)};
				frame.len  = lcdfs_pkg::LEN_SEG;
			end
			default: begin
				frame.bits = '0;
				frame.len  = '0;
			end
		endcase
	end

	lcdfs_shifter u_shifter (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.frame    (frame),
		.advance  (out_take),
		.busy     (busy),
		.bit_out  (serial_bit),
		.last_out (last)
	);

	assign out_valid = busy;

endmodule

/* dv/tb_top.sv */
module tb_top;

	localparam int LIMIT_CYCLES = 500000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 98;
	// Digit patterns 9 down to 0, digit n at bits [8n +: 8]
	localparam logic [79:0] SEG_ROM = {8'h7B, 8'h7F, 8'h70, 8'h5F, 8'h5B,
		8'h63, 8'h7A, 8'h3E, 8'h60, 8'h7D};

	typedef struct packed {
		logic [1:0] func;
		logic [4:0] address;
		logic [7:0] value;
		logic       dot;
	} lcd_req_t;

	typedef struct packed {
		logic serial_bit;
		logic last;
	} line_bit_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] func = lcdfs_pkg::FUNC_CMD;
	logic [4:0] address = 5'd0;
	logic [7:0] value = 8'd0;
	logic       dot = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       serial_bit;
	logic       last;

	lcd_req_t  pending_reqs[$];
	line_bit_t expected_bits[$];
	lcd_req_t  req_now;
	line_bit_t bit_want;
	int        idle_pct = 0;
	int        stall_pct = 0;
	int        errors = 0;
	int        cycle_cnt = 0;
	logic      hold_arm = 1'b0;
	logic      hold_on = 1'b0;

	lcd_controller_serial_frame_sender uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.address    (address),
		.value      (value),
		.dot        (dot),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.serial_bit (serial_bit),
		.last       (last)
	);

	always #5 clk = ~clk;

	// Work out the line bits of one request and queue them in send order
	function automatic void queue_frame_bits(logic [1:0] f, logic [4:0] a, logic [7:0] v,
			logic d);
		logic [16:0] word;
		logic [7:0]  seg;
		logic [5:0]  sent_addr;
		int          n;
		line_bit_t   lb;
		word = '0;
		n = 0;
		case (f)
			lcdfs_pkg::FUNC_CMD: begin
				word = {lcdfs_pkg::CMD_FLAG, v, 5'd0};
				n = 12;
			end
			lcdfs_pkg::FUNC_RAW, lcdfs_pkg::FUNC_DIGIT: begin
				if (f == lcdfs_pkg::FUNC_RAW)
					seg = v;
				else begin
					seg = (v <= 8'd9) ? SEG_ROM[v * 8 +: 8] : 8'h00;
					if (d)
						seg = seg | lcdfs_pkg::DOT_MASK;
				end
				// address zero wraps round to 63
				sent_addr = {a, 1'b0} - 6'd1;
				word[16:14] = lcdfs_pkg::SEG_FLAG;
				word[13:8] = sent_addr;
				// segment byte leaves LSB first
				for (int i = 0; i < 8; i++)
					word[7 - i] = seg[i];
				n = 17;
			end
			default: n = 0;
		endcase
		for (int i = 0; i < n; i++) begin
			lb.serial_bit = word[16 - i];
			lb.last = (i == n - 1);
			expected_bits.push_back(lb);
		end
	endfunction

	function automatic void add_req(logic [1:0] f, logic [4:0] a, logic [7:0] v, logic d);
		lcd_req_t r;
		r.func = f;
		r.address = a;
		r.value = v;
		r.dot = d;
		pending_reqs.push_back(r);
	endfunction

	// Random request: mostly valid functions, digits mostly in or near range
	function automatic void add_random_req();
		logic [1:0] f;
		logic [7:0] v;
		f = ($urandom_range(99, 0) < 8) ? lcdfs_pkg::FUNC_NONE : 2'($urandom_range(2, 0));
		v = 8'($urandom_range(255, 0));
		if (f == lcdfs_pkg::FUNC_DIGIT && $urandom_range(3, 0) != 0)
			v = 8'($urandom_range(11, 0));
		add_req(f, 5'($urandom_range(31, 0)), v, 1'($urandom_range(1, 0)));
	endfunction

	// Driver: predict each transfer, then offer the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				queue_frame_bits(func, address, value, dot);
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
					req_now = pending_reqs.pop_front();
					in_valid <= 1'b1;
					func <= req_now.func;
					address <= req_now.address;
					value <= req_now.value;
					dot <= req_now.dot;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each output transfer against the oldest expected bit
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bits.size() == 0) begin
					$error("unexpected bit: serial_bit=%0b last=%0b", serial_bit, last);
					errors++;
				end else begin
					bit_want = expected_bits.pop_front();
					if (serial_bit !== bit_want.serial_bit) begin
						$error("serial_bit: expected %0b, got %0b", bit_want.serial_bit,
							serial_bit);
						errors++;
					end
					if (last !== bit_want.last) begin
						$error("last: expected %0b, got %0b", bit_want.last, last);
						errors++;
					end
				end
			end
			out_stall <= hold_on || ($urandom_range(99, 0) < stall_pct);
		end
	end

	// Long receiver hold-off so the block backs up onto its input
	initial begin
		wait (hold_arm);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	// Watchdog
	initial begin
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[lcd_controller_serial_frame_sender] ERROR");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: flag and byte extremes, address wrap, every digit, blank digits
		add_req(lcdfs_pkg::FUNC_CMD, 5'd0, 8'h00, 1'b0);
		add_req(lcdfs_pkg::FUNC_CMD, 5'd31, 8'hFF, 1'b1);
		add_req(lcdfs_pkg::FUNC_CMD, 5'd10, 8'hA5, 1'b0);
		add_req(lcdfs_pkg::FUNC_RAW, 5'd0, 8'h00, 1'b0);
		add_req(lcdfs_pkg::FUNC_RAW, 5'd31, 8'hFF, 1'b1);
		add_req(lcdfs_pkg::FUNC_RAW, 5'd1, 8'h5A, 1'b0);
		for (int i = 0; i < 10; i++)
			add_req(lcdfs_pkg::FUNC_DIGIT, 5'(i * 3), 8'(i), 1'(i % 2));
		add_req(lcdfs_pkg::FUNC_DIGIT, 5'd0, 8'd10, 1'b1);
		add_req(lcdfs_pkg::FUNC_DIGIT, 5'd31, 8'hFF, 1'b0);
		add_req(lcdfs_pkg::FUNC_NONE, 5'd31, 8'hFF, 1'b1);
		add_req(lcdfs_pkg::FUNC_CMD, 5'd5, 8'h3C, 1'b0);

		// Random phases: idle percentages for sender and receiver
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				for (int i = 0; i < PHASE_ITEMS; i++)
					add_random_req();
			end
			case (ph)
				2: idle_pct = 46;
				3: begin
					idle_pct = 0;
					stall_pct = 46;
				end
				4: begin
					idle_pct = 8;
					stall_pct = 8;
				end
				default: begin
					idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			if (ph == 1)
				hold_arm = 1'b1;
			while (pending_reqs.size() != 0 || in_valid || expected_bits.size() != 0)
				@(negedge clk);
		end

		// Let any stray output show up before the verdict
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("[lcd_controller_serial_frame_sender] OK");
		else
			$display("[lcd_controller_serial_frame_sender] ERROR");
		$finish;
	end

endmodule

/* sim.f */
hdl/lcdfs_pkg.sv
hdl/lcdfs_shifter.sv
hdl/lcd_controller_serial_frame_sender.sv
dv/tb_top.sv
